// ===== rtl/core/multi_queue_shared_buffer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shared-buffer queue core
// Each macro expands to a concurrent assertion clocked on clk and disabled
// during rst, or to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_SHARED_BUFFER_CORE_ASSERT_SVH
`define MULTI_QUEUE_SHARED_BUFFER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define MQSB_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mqsb assertion failed");

// same-cycle implication
`define MQSB_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mqsb assertion failed");

// next-cycle implication
`define MQSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mqsb assertion failed");

`else

`define MQSB_ASSERT_ALWAYS(label, cond)
`define MQSB_ASSERT_IMPLY(label, ante, cons)
`define MQSB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/mqsb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_pkg
// Word types, operation and status codes, and sequencer states shared by
// the shared-buffer queue core.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BADQ  = 2'd3;

  // command word
  typedef struct packed {
    logic               opcode;
    logic [1:0]         queue_id;
    logic signed [31:0] data_in;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
  } out_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ENQ,
    S_LINK,
    S_DHEAD,
    S_DEQ
  } state_t;

endpackage

// ===== rtl/core/mqsb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module mqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/multi_queue_shared_buffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_core
// QUEUES FIFO queues kept as linked lists in one store of ENTRIES words,
// with the unused entries on a common free list.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (cmd) is taken at a clock edge where start is high and
//   busy is low. opcode selects enqueue of data_in or dequeue, queue_id the
//   queue. Every command gives exactly one result word on result, marked by
//   done for one cycle; the receiver has no way to hold it off.
//   States walked after the accepting edge (done follows the last):
//     bad queue number       none, busy stays low, done in the next cycle
//     enqueue, store full    S_ENQ
//     enqueue, empty queue   S_ENQ
//     enqueue, other queue   S_ENQ, S_LINK (second link write)
//     dequeue, empty queue   S_DHEAD
//     dequeue                S_DHEAD, S_DEQ (head read, then link/data read)
//   A new command may be taken in the cycle its predecessor's done is high.
//   The sequencing is set by the registered-read memories: each pointer
//   hop is one read.
//   Reset: after rst the core runs a clearing pass of max(ENTRIES, QUEUES)
//   addresses with busy high, chaining the free list and marking every queue
//   empty.
// ----------------------------------------------------------------------------
`include "multi_queue_shared_buffer_core_assert.svh"

module multi_queue_shared_buffer_core #(
  parameter int ENTRIES = 16,
  parameter int QUEUES  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mqsb_pkg::in_word_t cmd,
  output logic               done,
  output mqsb_pkg::out_word_t result
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int PW    = $clog2(ENTRIES + 1);
  localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int CLR_N = (ENTRIES > QUEUES) ? ENTRIES : QUEUES;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  // sequencer and pointer registers
  mqsb_pkg::state_t state, state_next;
  logic [CW-1:0]    clr, clr_next;
  logic [PW-1:0]    free_head, free_head_next;
  logic [IW-1:0]    slot, slot_next;
  logic             done_next;
  mqsb_pkg::out_word_t result_next;

  // latched command
  logic [QW-1:0]      q, q_next;
  logic signed [31:0] word, word_next;

  // memory ports
  logic          link_we;
  logic [IW-1:0] link_waddr, link_raddr;
  logic [PW-1:0] link_wdata, link_rd;
  logic          data_we;
  logic [IW-1:0] data_waddr, data_raddr;
  logic [31:0]   data_rd;
  logic          head_we;
  logic [QW-1:0] head_waddr, head_raddr;
  logic [PW-1:0] head_wdata, head_rd;
  logic          tail_we;
  logic [QW-1:0] tail_waddr, tail_raddr;
  logic [IW-1:0] tail_wdata, tail_rd;

  logic bad_q;
  logic clr_last;

  assign bad_q    = (32'(cmd.queue_id) >= QUEUES);
  assign clr_last = (32'(clr) == CLR_N - 1);
  assign busy     = (state != mqsb_pkg::S_IDLE);

  // per-entry links
  mqsb_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rd)
  );

  // per-entry data words
  mqsb_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_data (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(word),
    .raddr(data_raddr), .rdata(data_rd)
  );

  // queue heads
  mqsb_ram #(.WIDTH(PW), .DEPTH(QUEUES)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd)
  );

  // queue tails
  mqsb_ram #(.WIDTH(IW), .DEPTH(QUEUES)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .raddr(tail_raddr), .rdata(tail_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mqsb_pkg::S_CLEAR;
      clr       <= '0;
      free_head <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      free_head <= free_head_next;
      done      <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot   <= slot_next;
    q      <= q_next;
    word   <= word_next;
    result <= result_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    clr_next       = clr;
    free_head_next = free_head;
    slot_next      = slot;
    q_next         = q;
    word_next      = word;
    done_next      = 1'b0;
    result_next    = result;

    link_we    = 1'b0;
    link_waddr = slot;
    link_wdata = NIL;
    link_raddr = IW'(free_head);
    data_we    = 1'b0;
    data_waddr = IW'(free_head);
    data_raddr = IW'(head_rd);
    head_we    = 1'b0;
    head_waddr = q;
    head_wdata = NIL;
    head_raddr = q;
    tail_we    = 1'b0;
    tail_waddr = q;
    tail_wdata = IW'(free_head);
    tail_raddr = q;

    case (state)
      // chain entry i to i+1 and mark queues empty, one address a cycle
      mqsb_pkg::S_CLEAR: begin
        link_we    = (32'(clr) < ENTRIES);
        link_waddr = IW'(clr);
        link_wdata = (32'(clr) == ENTRIES - 1) ? NIL : PW'(32'(clr) + 1);
        head_we    = (32'(clr) < QUEUES);
        head_waddr = QW'(clr);
        head_wdata = NIL;
        clr_next   = clr + CW'(1);
        if (clr_last) begin
          state_next = mqsb_pkg::S_IDLE;
        end
      end

      // take a command; reads of head/tail/free link launch here
      mqsb_pkg::S_IDLE: begin
        head_raddr = QW'(cmd.queue_id);
        tail_raddr = QW'(cmd.queue_id);
        if (start) begin
          q_next    = QW'(cmd.queue_id);
          word_next = cmd.data_in;
          if (bad_q) begin
            done_next   = 1'b1;
            result_next = '{data_out: '0, status: mqsb_pkg::ST_BADQ};
          end else if (cmd.opcode == mqsb_pkg::OP_ENQ) begin
            state_next = mqsb_pkg::S_ENQ;
          end else begin
            state_next = mqsb_pkg::S_DHEAD;
          end
        end
      end

      // enqueue: report full if the free list is empty, else pop free list, store word, hook onto queue
      mqsb_pkg::S_ENQ: begin
        if (free_head == NIL) begin
          done_next   = 1'b1;
          result_next = '{data_out: '0, status: mqsb_pkg::ST_FULL};
          state_next  = mqsb_pkg::S_IDLE;
        end else begin
          free_head_next = link_rd;
          slot_next      = IW'(free_head);
          data_we        = 1'b1;
          tail_we        = 1'b1;
          link_we        = 1'b1;
          if (head_rd == NIL) begin
            head_we     = 1'b1;
            head_wdata  = free_head;
            link_waddr  = IW'(free_head);
            link_wdata  = NIL;
            done_next   = 1'b1;
            result_next = '{data_out: '0, status: mqsb_pkg::ST_OK};
            state_next  = mqsb_pkg::S_IDLE;
          end else begin
            link_waddr = tail_rd;
            link_wdata = free_head;
            state_next = mqsb_pkg::S_LINK;
          end
        end
      end

      // terminate the new tail entry
      mqsb_pkg::S_LINK: begin
        link_we     = 1'b1;
        link_waddr  = slot;
        link_wdata  = NIL;
        done_next   = 1'b1;
        result_next = '{data_out: '0, status: mqsb_pkg::ST_OK};
        state_next  = mqsb_pkg::S_IDLE;
      end

      // dequeue: head known, report empty or fetch its link and data
      mqsb_pkg::S_DHEAD: begin
        link_raddr = IW'(head_rd);
        data_raddr = IW'(head_rd);
        slot_next  = IW'(head_rd);
        if (head_rd == NIL) begin
          done_next   = 1'b1;
          result_next = '{data_out: '0, status: mqsb_pkg::ST_EMPTY};
          state_next  = mqsb_pkg::S_IDLE;
        end else begin
          state_next = mqsb_pkg::S_DEQ;
        end
      end

      // unlink head, push entry onto free list
      mqsb_pkg::S_DEQ: begin
        head_we        = 1'b1;
        head_wdata     = link_rd;
        link_we        = 1'b1;
        link_waddr     = slot;
        link_wdata     = free_head;
        free_head_next = {{(PW-IW){1'b0}}, slot};
        done_next      = 1'b1;
        result_next    = '{data_out: data_rd, status: mqsb_pkg::ST_OK};
        state_next     = mqsb_pkg::S_IDLE;
      end

      default: begin
        state_next = mqsb_pkg::S_IDLE;
      end
    endcase
  end

  // checks
  `MQSB_ASSERT_ALWAYS(a_free_head_range, free_head <= NIL)
  `MQSB_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
  `MQSB_ASSERT_IMPLY(a_link_after_enq, state == mqsb_pkg::S_LINK,
                     $past(state) == mqsb_pkg::S_ENQ)
  `MQSB_ASSERT_IMPLY(a_fail_zero_data, done && result.status != mqsb_pkg::ST_OK,
                     result.data_out == 0)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_queue_shared_buffer_core. Enqueue and dequeue
// words are fed to the core through its start/busy handshake. Each accepted
// word is run through a local linked-list model of the queues and the free
// list. Every result strobed on done is compared field by field with the
// oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int         ENTRIES      = 16;
  localparam int         QUEUES       = 4;
  localparam logic [4:0] NULL_ENTRY   = 5'(ENTRIES);
  localparam int         RANDOM_WORDS = 1625;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         MAX_PRINTS   = 50;

  logic                clk   = 1'b0;
  logic                rst   = 1'b1;
  logic                start = 1'b0;
  mqsb_pkg::in_word_t  cmd   = '0;
  logic                busy;
  logic                done;
  mqsb_pkg::out_word_t result;

  // stimulus and scoreboard
  mqsb_pkg::in_word_t  pending_words[$];
  mqsb_pkg::out_word_t expected_results[$];
  int        total_words  = 0;
  int        words_sent   = 0;
  int        mismatches   = 0;
  int        quiet_cycles = 0;
  logic      word_taken   = 1'b0;

  // local picture of the queues: head/tail per queue, one link per entry
  logic [4:0]         q_first[QUEUES];
  logic [4:0]         q_last[QUEUES];
  logic [4:0]         next_link[ENTRIES];
  logic signed [31:0] slot_word[ENTRIES];
  logic [4:0]         free_top;

  multi_queue_shared_buffer_core #(
    .ENTRIES(ENTRIES),
    .QUEUES (QUEUES)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("ERROR %0t: %s", $realtime, msg);
  endtask

  // apply one command to the local queues and return the result it gives
  function automatic mqsb_pkg::out_word_t run_queue_op(input mqsb_pkg::in_word_t w);
    mqsb_pkg::out_word_t r;
    logic [4:0]          slot;
    int                  q;
    r.data_out = '0;
    r.status   = mqsb_pkg::ST_OK;
    q          = int'(w.queue_id);
    if (q >= QUEUES) begin
      r.status = mqsb_pkg::ST_BADQ;
    end else if (w.opcode == mqsb_pkg::OP_ENQ) begin
      slot = free_top;
      if (slot == NULL_ENTRY) begin
        r.status = mqsb_pkg::ST_FULL;
      end else begin
        free_top = next_link[slot];
        if (q_first[q] == NULL_ENTRY) q_first[q] = slot;
        else next_link[q_last[q]] = slot;
        next_link[slot] = NULL_ENTRY;
        q_last[q]       = slot;
        slot_word[slot] = w.data_in;
      end
    end else begin
      slot = q_first[q];
      if (slot == NULL_ENTRY) begin
        r.status = mqsb_pkg::ST_EMPTY;
      end else begin
        q_first[q]      = next_link[slot];
        next_link[slot] = free_top;
        free_top        = slot;
        r.data_out      = slot_word[slot];
      end
    end
    return r;
  endfunction

  task automatic add_word(input logic op, input int q, input logic [31:0] data);
    mqsb_pkg::in_word_t w;
    w.opcode   = op;
    w.queue_id = q[1:0];
    w.data_in  = data;
    pending_words.push_back(w);
  endtask

  // driver: a word stays on cmd until taken, idle gaps only between words
  always @(negedge clk) begin
    int gap_pct;
    gap_pct = (words_sent < total_words / 3) ? 8 :
              (words_sent < 2 * total_words / 3) ? 69 : 0;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
        cmd   <= pending_words.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, predict accepted words, watch for a hang
  always @(posedge clk) begin
    mqsb_pkg::out_word_t want;
    if (rst) begin
      word_taken   = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: data_out %0d status %0d",
                                    result.data_out, result.status));
        end else begin
          want = expected_results.pop_front();
          if (result.data_out !== want.data_out)
            report_mismatch($sformatf("data_out %0d, expected %0d",
                                      result.data_out, want.data_out));
          if (result.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, want.status));
        end
      end
      word_taken = start && !busy;
      if (word_taken) begin
        expected_results.push_back(run_queue_op(cmd));
        words_sent++;
      end
      if (word_taken || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("multi_queue_shared_buffer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] corner_data[8];
    int          enq_pct;
    int          run_left;
    logic        op;

    // model state after reset: queues empty, free list chained in order
    for (int i = 0; i < QUEUES; i++) begin
      q_first[i] = NULL_ENTRY;
      q_last[i]  = '0;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      next_link[i] = 5'(i + 1);
      slot_word[i] = '0;
    end
    free_top = '0;

    corner_data = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                    32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001, 32'hffff_fffe};

    // directed: dequeue every empty queue, fill the store past full,
    // then drain the head of each queue
    for (int q = 0; q < QUEUES; q++) add_word(mqsb_pkg::OP_DEQ, q, $urandom());
    for (int i = 0; i <= ENTRIES; i++)
      add_word(mqsb_pkg::OP_ENQ, i % QUEUES, (i < 8) ? corner_data[i] : $urandom());
    for (int q = 0; q < QUEUES; q++) add_word(mqsb_pkg::OP_DEQ, q, $urandom());

    // random: runs biased toward filling, draining, or a balanced mix
    run_left = 0;
    enq_pct  = 50;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(120, 20);
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 15;
          default: enq_pct = 50;
        endcase
      end
      run_left--;
      op = ($urandom_range(99) < enq_pct) ? mqsb_pkg::OP_ENQ : mqsb_pkg::OP_DEQ;
      add_word(op, $urandom_range(QUEUES - 1), $urandom());
    end
    total_words = pending_words.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every word to go out and every result to come back
    do @(posedge clk);
    while (pending_words.size() != 0 || start || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("multi_queue_shared_buffer_core: match");
    end else begin
      $display("multi_queue_shared_buffer_core: mismatch");
    end
    $finish;
  end

endmodule
